/* hw/rtl/iwo_pkg.sv */
package iwo_pkg;

    // fixed-point formats
    localparam int PHASE_BITS      = 32;
    localparam int PHASE_FRAC_BITS = 20;
    localparam int SAMPLE_BITS     = 16;
    localparam int TABLE_DEPTH     = 4096;
    localparam int ADDR_BITS       = PHASE_BITS - PHASE_FRAC_BITS;
    localparam int LEN_BITS        = 13;
    localparam int SOR_BITS        = 32;
    localparam int FREQ_BITS       = 32;
    localparam int START_BITS      = 32;
    localparam int MIN_LEN         = 4;
    localparam int MIN_LEN_LOG2    = 2;

    // Q16.16 * Q8.24 carries 40 fraction bits
    localparam int STEP_PROD_BITS  = FREQ_BITS + SOR_BITS;
    localparam int STEP_SHIFT      = 40 - PHASE_FRAC_BITS;
    localparam int STEP_RAW_BITS   = STEP_PROD_BITS - STEP_SHIFT;
    localparam int START_PROD_BITS = LEN_BITS + START_BITS;
    localparam int START_SHIFT     = START_BITS - PHASE_FRAC_BITS;

    // table length in phase units, up to and including 2^PHASE_BITS
    localparam int LFIX_BITS       = LEN_BITS + PHASE_FRAC_BITS;

    // shift-subtract reduction of the phase after the length was lowered
    localparam int RED_TOP         = PHASE_BITS - MIN_LEN_LOG2 - PHASE_FRAC_BITS - 1;
    localparam int RED_BITS        = LFIX_BITS + RED_TOP;
    localparam int RED_K_BITS      = $clog2(RED_TOP + 1);

    // interpolation
    localparam int DIFF_BITS       = SAMPLE_BITS + 1;
    localparam int IPROD_BITS      = SAMPLE_BITS + PHASE_FRAC_BITS;
    localparam int SUM_BITS        = SAMPLE_BITS + 2;

    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_SET_PHASE = 2'd2;

    localparam logic CFG_TABLE_LENGTH   = 1'b0;
    localparam logic CFG_SIZE_OVER_RATE = 1'b1;

    localparam logic [LEN_BITS-1:0] TABLE_LENGTH_RST   = 13'd4096;
    localparam logic [SOR_BITS-1:0] SIZE_OVER_RATE_RST = 32'd1431655;

    typedef struct packed {
        logic [1:0]                    opcode;
        logic [ADDR_BITS-1:0]          table_index;
        logic signed [SAMPLE_BITS-1:0] table_value;
        logic signed [FREQ_BITS-1:0]   frequency;
        logic [START_BITS-1:0]         start_phase;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_valid;
        logic [PHASE_BITS-1:0]         phase_now;
    } t_out_item;

    typedef struct packed {
        logic                   we;
        logic [ADDR_BITS-1:0]   addr;
        logic [SAMPLE_BITS-1:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic                 re;
        logic [ADDR_BITS-1:0] addr_a;
        logic [ADDR_BITS-1:0] addr_b;
    } t_tbl_rd;

endpackage

/* hw/rtl/interpolating_wavetable_oscillator.sv */
// each item passes stages P, A, B, C and the output register; one item per cycle
// sustained unless the receiver stalls; the phase update loops within the table stage,
// so ticks run back to back; a tick that finds the phase at or beyond a lowered
// table_length stalls while a shift-subtract unit reduces the phase, one step per cycle
// reset (synchronous, active low) clears the phase, empties the pipeline and loads
// table_length 4096 and size_over_rate 1431655; the waveform table is not cleared
module interpolating_wavetable_oscillator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  iwo_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output iwo_pkg::t_out_item   o_out_data,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int PB  = iwo_pkg::PHASE_BITS;
    localparam int FB  = iwo_pkg::PHASE_FRAC_BITS;
    localparam int SB  = iwo_pkg::SAMPLE_BITS;
    localparam int AB  = iwo_pkg::ADDR_BITS;
    localparam int LB  = iwo_pkg::LEN_BITS;
    localparam int LFB = iwo_pkg::LFIX_BITS;

    // configuration
    logic [LB-1:0]                r_table_length;
    logic [iwo_pkg::SOR_BITS-1:0] r_size_over_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length   <= iwo_pkg::TABLE_LENGTH_RST;
            r_size_over_rate <= iwo_pkg::SIZE_OVER_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iwo_pkg::CFG_TABLE_LENGTH:   r_table_length   <= i_cfg_data[LB-1:0];
                iwo_pkg::CFG_SIZE_OVER_RATE: r_size_over_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [LB-1:0]  used_len;
    logic [LFB-1:0] lfix;
    logic [LFB-1:0] lfix_m1;

    always_comb begin
        if (r_table_length < LB'(iwo_pkg::MIN_LEN)) begin
            used_len = LB'(iwo_pkg::MIN_LEN);
        end else if (r_table_length > LB'(iwo_pkg::TABLE_DEPTH)) begin
            used_len = LB'(iwo_pkg::TABLE_DEPTH);
        end else begin
            used_len = r_table_length;
        end
    end

    assign lfix    = {used_len, FB'(0)};
    assign lfix_m1 = lfix - LFB'(1);

    // handshake chain
    logic r_p_valid, r_a_valid, r_b_valid, r_c_valid, r_o_valid;
    logic in_fire, p_adv, a_adv, b_adv, c_adv;
    logic p_free, a_free, b_free, c_free, o_free;
    logic a_reduce;

    assign o_free  = !r_o_valid || i_out_ready;
    assign c_adv   = r_c_valid && o_free;
    assign c_free  = !r_c_valid || c_adv;
    assign b_adv   = r_b_valid && c_free;
    assign b_free  = !r_b_valid || b_adv;
    assign a_adv   = r_a_valid && b_free && !a_reduce;
    assign a_free  = !r_a_valid || a_adv;
    assign p_adv   = r_p_valid && a_free;
    assign p_free  = !r_p_valid || p_adv;
    assign in_fire = i_in_valid && p_free;

    assign o_in_ready = p_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_free) begin
                r_p_valid <= in_fire;
            end
            if (a_free) begin
                r_a_valid <= p_adv;
            end
            if (b_free) begin
                r_b_valid <= a_adv;
            end
            if (c_free) begin
                r_c_valid <= b_adv;
            end
            if (o_free) begin
                r_o_valid <= c_adv;
            end
        end
    end

    // stage P: products of the frequency and of the start fraction
    logic [1:0]                           r_p_op;
    logic [AB-1:0]                        r_p_index;
    logic [SB-1:0]                        r_p_value;
    logic                                 r_p_neg;
    logic [iwo_pkg::STEP_PROD_BITS-1:0]   r_p_prod;
    logic [PB-1:0]                        r_p_start;

    logic [iwo_pkg::FREQ_BITS-1:0]        freq_bits;
    logic [iwo_pkg::FREQ_BITS-1:0]        freq_mag;
    logic [iwo_pkg::START_PROD_BITS-1:0]  start_prod;

    assign freq_bits  = i_in_data.frequency;
    // the most negative value maps onto its own bit pattern, as wanted
    assign freq_mag   = freq_bits[iwo_pkg::FREQ_BITS-1] ? (~freq_bits + 32'd1) : freq_bits;
    assign start_prod = iwo_pkg::START_PROD_BITS'(used_len)
                      * iwo_pkg::START_PROD_BITS'(i_in_data.start_phase);

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_p_op    <= i_in_data.opcode;
            r_p_index <= i_in_data.table_index;
            r_p_value <= i_in_data.table_value;
            r_p_neg   <= freq_bits[iwo_pkg::FREQ_BITS-1];
            r_p_prod  <= iwo_pkg::STEP_PROD_BITS'(freq_mag)
                       * iwo_pkg::STEP_PROD_BITS'(r_size_over_rate);
            r_p_start <= PB'(start_prod >> iwo_pkg::START_SHIFT);
        end
    end

    // stage P -> A: scale and saturate the step below one table length
    logic [iwo_pkg::STEP_RAW_BITS-1:0] step_raw;
    logic [PB-1:0]                     step_sat;

    assign step_raw = iwo_pkg::STEP_RAW_BITS'(r_p_prod >> iwo_pkg::STEP_SHIFT);
    assign step_sat = (step_raw > iwo_pkg::STEP_RAW_BITS'(lfix_m1)) ? PB'(lfix_m1)
                                                                  : PB'(step_raw);

    logic [1:0]    r_a_op;
    logic [AB-1:0] r_a_index;
    logic [SB-1:0] r_a_value;
    logic          r_a_neg;
    logic [PB-1:0] r_a_step;
    logic [PB-1:0] r_a_start;

    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_a_op    <= r_p_op;
            r_a_index <= r_p_index;
            r_a_value <= r_p_value;
            r_a_neg   <= r_p_neg;
            r_a_step  <= step_sat;
            r_a_start <= r_p_start;
        end
    end

    // stage A: phase register, table access
    logic [PB-1:0]                 r_phase;
    logic [PB-1:0]                 n_phase;
    logic [iwo_pkg::RED_K_BITS-1:0] r_red_k;
    logic                          a_tick;
    logic [iwo_pkg::RED_BITS-1:0]  red_sub;
    logic                          red_hit;
    logic [LFB-1:0]                ph_ext;
    logic [LFB-1:0]                step_ext;
    logic [LFB-1:0]                ph_sum;
    logic [LFB-1:0]                ph_tick;
    logic [AB-1:0]                 rd_base;
    logic [LB-1:0]                 rd_next_raw;
    logic [AB-1:0]                 rd_next;
    logic [PB-1:0]                 phase_now;

    assign a_tick   = (r_a_op == iwo_pkg::OP_TICK);
    assign ph_ext   = LFB'(r_phase);
    assign step_ext = LFB'(r_a_step);
    assign a_reduce = r_a_valid && a_tick && (ph_ext >= lfix);
    assign red_sub  = iwo_pkg::RED_BITS'(lfix) << r_red_k;
    assign red_hit  = iwo_pkg::RED_BITS'(r_phase) >= red_sub;

    always_comb begin
        if (r_a_neg) begin
            if (ph_ext >= step_ext) begin
                ph_sum  = ph_ext - step_ext;
            end else begin
                ph_sum  = ph_ext + lfix - step_ext;
            end
            ph_tick = ph_sum;
        end else begin
            ph_sum = ph_ext + step_ext;
            if (ph_sum >= lfix) begin
                ph_tick = ph_sum - lfix;
            end else begin
                ph_tick = ph_sum;
            end
        end
    end

    assign rd_base     = r_phase[PB-1 -: AB];
    assign rd_next_raw = LB'(rd_base) + LB'(1);
    assign rd_next     = (rd_next_raw >= used_len) ? AB'(0) : rd_next_raw[AB-1:0];

    always_comb begin
        case (r_a_op)
            iwo_pkg::OP_TICK:      phase_now = PB'(ph_tick);
            iwo_pkg::OP_SET_PHASE: phase_now = r_a_start;
            default:               phase_now = r_phase;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (a_reduce) begin
            if (red_hit) begin
                n_phase = r_phase - PB'(red_sub);
            end
        end else if (a_adv) begin
            n_phase = phase_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_red_k <= iwo_pkg::RED_K_BITS'(iwo_pkg::RED_TOP);
        end else begin
            r_phase <= n_phase;
            if (!a_reduce) begin
                r_red_k <= iwo_pkg::RED_K_BITS'(iwo_pkg::RED_TOP);
            end else if (r_red_k != '0) begin
                r_red_k <= r_red_k - iwo_pkg::RED_K_BITS'(1);
            end
        end
    end

    iwo_pkg::t_tbl_wr tbl_wr;
    iwo_pkg::t_tbl_rd tbl_rd;
    logic [SB-1:0]    rdata_a;
    logic [SB-1:0]    rdata_b;

    assign tbl_wr.we     = a_adv && (r_a_op == iwo_pkg::OP_WRITE);
    assign tbl_wr.addr   = r_a_index;
    assign tbl_wr.data   = r_a_value;
    assign tbl_rd.re     = a_adv && a_tick;
    assign tbl_rd.addr_a = rd_base;
    assign tbl_rd.addr_b = rd_next;

    iwo_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd      (tbl_rd),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    logic          r_b_tick;
    logic [FB-1:0] r_b_frac;
    logic [PB-1:0] r_b_phase;

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_tick  <= a_tick;
            r_b_frac  <= r_phase[FB-1:0];
            r_b_phase <= phase_now;
        end
    end

    // stage B: difference times fraction
    logic [iwo_pkg::DIFF_BITS-1:0] diff;
    logic [iwo_pkg::DIFF_BITS-1:0] diff_mag;

    assign diff     = {rdata_b[SB-1], rdata_b} - {rdata_a[SB-1], rdata_a};
    assign diff_mag = diff[iwo_pkg::DIFF_BITS-1] ? (~diff + iwo_pkg::DIFF_BITS'(1)) : diff;

    logic                           r_c_tick;
    logic [PB-1:0]                  r_c_phase;
    logic [SB-1:0]                  r_c_a;
    logic                           r_c_dneg;
    logic [iwo_pkg::IPROD_BITS-1:0] r_c_prod;

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_c_tick  <= r_b_tick;
            r_c_phase <= r_b_phase;
            r_c_a     <= rdata_a;
            r_c_dneg  <= diff[iwo_pkg::DIFF_BITS-1];
            r_c_prod  <= iwo_pkg::IPROD_BITS'(diff_mag[SB-1:0])
                       * iwo_pkg::IPROD_BITS'(r_b_frac);
        end
    end

    // stage C: floor of the scaled difference, added to the base sample
    logic [iwo_pkg::IPROD_BITS-1:0] prod_adj;
    logic [SB-1:0]                  t_mag;
    logic [iwo_pkg::SUM_BITS-1:0]   t_ext;
    logic [iwo_pkg::SUM_BITS-1:0]   v_sum;

    // a negative difference rounds away from zero, which is floor
    assign prod_adj = r_c_dneg ? (r_c_prod + iwo_pkg::IPROD_BITS'({FB{1'b1}})) : r_c_prod;
    assign t_mag    = SB'(prod_adj >> FB);
    assign t_ext    = r_c_dneg ? (~iwo_pkg::SUM_BITS'(t_mag) + iwo_pkg::SUM_BITS'(1))
                               : iwo_pkg::SUM_BITS'(t_mag);
    assign v_sum    = {{2{r_c_a[SB-1]}}, r_c_a} + t_ext;

    iwo_pkg::t_out_item r_o_data;

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_o_data.sample       <= r_c_tick ? v_sum[SB-1:0] : SB'(0);
            r_o_data.sample_valid <= r_c_tick;
            r_o_data.phase_now    <= r_c_phase;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

/* hw/rtl/iwo_table.sv */
module iwo_table (
    input  logic                                i_clk,
    input  iwo_pkg::t_tbl_wr                    i_wr,
    input  iwo_pkg::t_tbl_rd                    i_rd,
    output logic [iwo_pkg::SAMPLE_BITS-1:0]     o_rdata_a,
    output logic [iwo_pkg::SAMPLE_BITS-1:0]     o_rdata_b
);

    logic [iwo_pkg::SAMPLE_BITS-1:0] r_mem [iwo_pkg::TABLE_DEPTH];
    logic [iwo_pkg::SAMPLE_BITS-1:0] r_rdata_a;
    logic [iwo_pkg::SAMPLE_BITS-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_rdata_a <= r_mem[i_rd.addr_a];
            r_rdata_b <= r_mem[i_rd.addr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* dv/tb_interpolating_wavetable_oscillator.sv */
`timescale 1ns / 100ps

module tb_interpolating_wavetable_oscillator;

    localparam longint FRAC_MASK = (64'd1 << iwo_pkg::PHASE_FRAC_BITS) - 1;
    localparam logic [1:0] OP_NONE = 2'd3;

    // tracks table, phase and registers; holds the results the block owes us, one per input item
    class wavetable_tracker;
        logic signed [iwo_pkg::SAMPLE_BITS-1:0] wave [iwo_pkg::TABLE_DEPTH];
        bit [iwo_pkg::TABLE_DEPTH-1:0]          loaded;
        logic [iwo_pkg::PHASE_BITS-1:0]         phase;
        logic [iwo_pkg::LEN_BITS-1:0]           table_length;
        logic [iwo_pkg::SOR_BITS-1:0]           size_over_rate;
        iwo_pkg::t_out_item                     expected_samples [$];
        int                                     errors;

        function void init();
            phase          = '0;
            table_length   = iwo_pkg::TABLE_LENGTH_RST;
            size_over_rate = iwo_pkg::SIZE_OVER_RATE_RST;
            loaded         = '0;
            errors         = 0;
            expected_samples.delete();
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function void write_register(logic idx, logic [31:0] value);
            if (idx == iwo_pkg::CFG_TABLE_LENGTH) begin
                table_length = value[iwo_pkg::LEN_BITS-1:0];
            end else begin
                size_over_rate = value;
            end
        endfunction

        function logic [iwo_pkg::LEN_BITS-1:0] active_length();
            if (table_length < iwo_pkg::MIN_LEN) begin
                return iwo_pkg::LEN_BITS'(iwo_pkg::MIN_LEN);
            end
            if (table_length > iwo_pkg::TABLE_DEPTH) begin
                return iwo_pkg::LEN_BITS'(iwo_pkg::TABLE_DEPTH);
            end
            return table_length;
        endfunction

        function logic [iwo_pkg::LFIX_BITS-1:0] span();
            return {active_length(), {iwo_pkg::PHASE_FRAC_BITS{1'b0}}};
        endfunction

        // entries a tick would read from the current phase
        function void tick_reads(output logic [iwo_pkg::ADDR_BITS-1:0] rd_a,
                                 output logic [iwo_pkg::ADDR_BITS-1:0] rd_b);
            logic [iwo_pkg::LFIX_BITS-1:0] ph;
            logic [iwo_pkg::LEN_BITS-1:0]  nxt;
            ph = {1'b0, phase};
            if (ph >= span()) ph = ph % span();
            rd_a = ph[iwo_pkg::PHASE_BITS-1:iwo_pkg::PHASE_FRAC_BITS];
            nxt = {1'b0, rd_a} + 1'b1;
            if (nxt >= active_length()) nxt = '0;
            rd_b = nxt[iwo_pkg::ADDR_BITS-1:0];
        endfunction

        function void note_input(iwo_pkg::t_in_item it);
            iwo_pkg::t_out_item                     res;
            logic [iwo_pkg::LFIX_BITS-1:0]          ph;
            logic [iwo_pkg::LFIX_BITS-1:0]          advance;
            logic [iwo_pkg::LFIX_BITS-1:0]          lim;
            logic [iwo_pkg::ADDR_BITS-1:0]          rd_a;
            logic [iwo_pkg::ADDR_BITS-1:0]          rd_b;
            logic signed [iwo_pkg::SAMPLE_BITS-1:0] a;
            logic signed [iwo_pkg::SAMPLE_BITS-1:0] b;
            logic [iwo_pkg::PHASE_FRAC_BITS-1:0]    frac;
            logic [31:0]                            mag;
            logic [63:0]                            prod;
            logic [iwo_pkg::START_PROD_BITS-1:0]    sp_prod;
            longint                                 diff;
            longint                                 part;
            logic                                   neg;
            res = '0;
            case (it.opcode)
                iwo_pkg::OP_WRITE: begin
                    wave[it.table_index]   = it.table_value;
                    loaded[it.table_index] = 1'b1;
                end
                iwo_pkg::OP_TICK: begin
                    // phase left beyond a lowered length is folded back first
                    ph = {1'b0, phase};
                    if (ph >= span()) ph = ph % span();
                    phase = ph[iwo_pkg::PHASE_BITS-1:0];
                    tick_reads(rd_a, rd_b);
                    a    = wave[rd_a];
                    b    = wave[rd_b];
                    frac = phase[iwo_pkg::PHASE_FRAC_BITS-1:0];
                    diff = longint'(b) - longint'(a);
                    if (diff >= 0) begin
                        part = (diff * longint'(frac)) >>> iwo_pkg::PHASE_FRAC_BITS;
                    end else begin
                        part = -(((-diff) * longint'(frac) + FRAC_MASK)
                                 >>> iwo_pkg::PHASE_FRAC_BITS);
                    end
                    res.sample       = iwo_pkg::SAMPLE_BITS'(longint'(a) + part);
                    res.sample_valid = 1'b1;

                    neg = it.frequency[iwo_pkg::FREQ_BITS-1];
                    mag = it.frequency;
                    if (neg) mag = ~mag + 1'b1;
                    prod = 64'(mag) * 64'(size_over_rate);
                    prod = prod >> iwo_pkg::STEP_SHIFT;
                    lim  = span() - 1'b1;
                    advance = (prod > 64'(lim)) ? lim : prod[iwo_pkg::LFIX_BITS-1:0];
                    if (neg) begin
                        if (ph >= advance) ph = ph - advance;
                        else ph = ph + span() - advance;
                    end else begin
                        ph = ph + advance;
                        if (ph >= span()) ph = ph - span();
                    end
                    phase = ph[iwo_pkg::PHASE_BITS-1:0];
                end
                iwo_pkg::OP_SET_PHASE: begin
                    sp_prod = iwo_pkg::START_PROD_BITS'(active_length())
                            * iwo_pkg::START_PROD_BITS'(it.start_phase);
                    phase = iwo_pkg::PHASE_BITS'(sp_prod >> iwo_pkg::START_SHIFT);
                end
                default: begin
                end
            endcase
            res.phase_now = phase;
            expected_samples.push_back(res);
        endfunction

        function void check_result(iwo_pkg::t_out_item got);
            iwo_pkg::t_out_item want;
            if (expected_samples.size() == 0) begin
                $error("result with no item outstanding: sample %0d valid %0b phase_now %0h",
                       got.sample, got.sample_valid, got.phase_now);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            if (got.sample !== want.sample) begin
                $error("sample: expected %0d, got %0d", want.sample, got.sample);
                errors++;
            end
            if (got.sample_valid !== want.sample_valid) begin
                $error("sample_valid: expected %0b, got %0b", want.sample_valid, got.sample_valid);
                errors++;
            end
            if (got.phase_now !== want.phase_now) begin
                $error("phase_now: expected %0h, got %0h", want.phase_now, got.phase_now);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    iwo_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    iwo_pkg::t_out_item o_out_data;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [31:0]        i_cfg_data;

    wavetable_tracker osc_model;
    bit               calm;

    interpolating_wavetable_oscillator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_frequency();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3, 4: return $urandom;
            default: begin
                // a few table entries per tick at the nominal scale
                mag = $urandom_range(0, 32'h0040_0000);
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    // each data field random, opcode set to write; the caller overrides what the opcode uses
    function automatic iwo_pkg::t_in_item noise_item();
        iwo_pkg::t_in_item it;
        it.opcode      = iwo_pkg::OP_WRITE;
        it.table_index = iwo_pkg::ADDR_BITS'($urandom);
        it.table_value = iwo_pkg::SAMPLE_BITS'($urandom);
        it.frequency   = $urandom;
        it.start_phase = $urandom;
        return it;
    endfunction

    task automatic send_item(input iwo_pkg::t_in_item item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        osc_model.note_input(item);
    endtask

    task automatic send_write(input logic [iwo_pkg::ADDR_BITS-1:0] idx,
                              input logic [iwo_pkg::SAMPLE_BITS-1:0] value);
        iwo_pkg::t_in_item item;
        item             = noise_item();
        item.opcode      = iwo_pkg::OP_WRITE;
        item.table_index = idx;
        item.table_value = value;
        send_item(item);
    endtask

    task automatic send_set_phase(input logic [31:0] start);
        iwo_pkg::t_in_item item;
        item             = noise_item();
        item.opcode      = iwo_pkg::OP_SET_PHASE;
        item.start_phase = start;
        send_item(item);
    endtask

    task automatic send_unused_op();
        iwo_pkg::t_in_item item;
        item        = noise_item();
        item.opcode = OP_NONE;
        send_item(item);
    endtask

    // entries a tick is about to read get loaded first
    task automatic send_tick(input logic [31:0] freq);
        logic [iwo_pkg::ADDR_BITS-1:0] rd_a;
        logic [iwo_pkg::ADDR_BITS-1:0] rd_b;
        iwo_pkg::t_in_item             item;
        osc_model.tick_reads(rd_a, rd_b);
        if (!osc_model.loaded[rd_a]) send_write(rd_a, iwo_pkg::SAMPLE_BITS'($urandom));
        if (!osc_model.loaded[rd_b]) send_write(rd_b, iwo_pkg::SAMPLE_BITS'($urandom));
        item           = noise_item();
        item.opcode    = iwo_pkg::OP_TICK;
        item.frequency = freq;
        send_item(item);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (osc_model.pending() != 0) @(posedge i_clk);
        // covers pipeline depth plus a phase reduction
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        osc_model.write_register(idx, value);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) osc_model.check_result(o_out_data);
    end

    // receiver: runs of ready with stalls in between
    initial begin
        int hold;
        i_out_ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            hold = pick_gap();
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [iwo_pkg::LEN_BITS-1:0] len_plan [10];
        logic [iwo_pkg::SOR_BITS-1:0] sor_plan [10];
        int                           per_phase;
        int                           r;
        logic [iwo_pkg::LEN_BITS-1:0] len_now;

        osc_model = new;
        osc_model.init();
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = iwo_pkg::CFG_TABLE_LENGTH;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, guard wrap, saturated steps, unused opcode
        send_write(12'd0, 16'h8000);
        send_write(12'd1, 16'h7FFF);
        send_write(12'd4095, 16'h7FFF);
        send_write(12'd4094, 16'h8000);
        send_tick(32'h0000_0000);
        send_set_phase(32'hFFFF_FFFF);
        send_tick(32'h7FFF_FFFF);
        send_set_phase(32'h8000_0000);
        send_tick(32'h8000_0000);
        send_tick(32'hFFFF_FFFF);
        send_unused_op();
        send_set_phase(32'h0000_0001);
        send_tick(32'h0000_0001);
        send_write(12'd2, 16'h0000);
        send_set_phase(32'h0000_0000);
        send_tick(32'h0001_0000);

        len_plan = '{13'd4096, 13'd4, 13'd0, 13'd8191, 13'd1000,
                     13'd64, 13'd3, 13'd4097, 13'd0, 13'd17};
        sor_plan = '{iwo_pkg::SIZE_OVER_RATE_RST, 32'hFFFF_FFFF, 32'h0, 32'h0,
                     32'h0100_0000, 32'h0001_0000, 32'h0, 32'h0020_0000, 32'h0,
                     32'h0000_0001};
        len_plan[8] = iwo_pkg::LEN_BITS'($urandom_range(iwo_pkg::MIN_LEN,
                                                        iwo_pkg::TABLE_DEPTH));
        sor_plan[3] = $urandom;
        sor_plan[6] = $urandom_range(0, 32'h0040_0000);
        sor_plan[8] = $urandom;
        // ticks also pull in writes for entries not loaded yet
        per_phase   = 125;

        for (int p = 0; p < 10; p++) begin
            write_register(iwo_pkg::CFG_TABLE_LENGTH, {19'($urandom), len_plan[p]});
            write_register(iwo_pkg::CFG_SIZE_OVER_RATE, sor_plan[p]);
            calm    = (p % 4 == 3);
            len_now = osc_model.active_length();
            // a lowered length can leave the phase out of range for this tick
            send_tick(pick_frequency());
            for (int n = 0; n < per_phase; n++) begin
                if (p == 2 && n == per_phase / 2) drain_results();
                r = $urandom_range(0, 99);
                if (r < 68) begin
                    send_tick(pick_frequency());
                end else if (r < 80) begin
                    send_write(iwo_pkg::ADDR_BITS'($urandom),
                               iwo_pkg::SAMPLE_BITS'($urandom));
                end else if (r < 89) begin
                    send_set_phase($urandom);
                end else if (r < 94) begin
                    send_unused_op();
                end else begin
                    // refresh the entries around the wrap point
                    send_write(iwo_pkg::ADDR_BITS'(len_now - 1'b1),
                               iwo_pkg::SAMPLE_BITS'($urandom));
                    send_write(12'd0, iwo_pkg::SAMPLE_BITS'($urandom));
                end
            end
        end

        calm = 1'b0;
        drain_results();
        if (osc_model.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
